[rtl/sdrd_pkg.sv]
// Shared constants and types for the SD SPI read response deframer.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package sdrd_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int COUNT_W     = 13;
    localparam int R1_LIMIT_W  = 13;
    localparam int TOK_LIMIT_W = 10;
    localparam int CFG_DATA_W  = 13;
    localparam int INDEX_W     = 9;
    localparam int PHASE_W     = 3;

    localparam logic [R1_LIMIT_W-1:0]  R1_LIMIT_RST  = R1_LIMIT_W'(8185);
    localparam logic [TOK_LIMIT_W-1:0] TOK_LIMIT_RST = TOK_LIMIT_W'(512);
    localparam logic [COUNT_W-1:0]     LAST_COUNT    = COUNT_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_R1    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TOKEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_NO_R1    = 2'd1;
    localparam logic [1:0] ST_R1_ERR   = 2'd2;
    localparam logic [1:0] ST_NO_TOKEN = 2'd3;

    // configuration register indexes
    localparam logic CFG_R1_LIMIT  = 1'b0;
    localparam logic CFG_TOK_LIMIT = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
        logic [1:0]         status;
        logic [7:0]         r1_value;
    } result_t;

endpackage

[rtl/sdrd_parser.sv]
// Parse state and per-byte decode for the read response deframer.
// Depends on sdrd_pkg.
`timescale 1ns / 1ps

module sdrd_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sdrd_pkg::R1_LIMIT_W-1:0]     r1_limit,
    input  logic [sdrd_pkg::TOK_LIMIT_W-1:0]    tok_limit,
    input  logic                                advance,
    input  logic [7:0]                          rx_byte,
    input  logic                                first_byte,
    output sdrd_pkg::result_t                   result
);

    logic [sdrd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [sdrd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   r1_reg, r1_next;

    logic [sdrd_pkg::PHASE_W-1:0] ph_eff;
    logic [sdrd_pkg::COUNT_W-1:0] cnt_eff;
    logic [sdrd_pkg::COUNT_W-1:0] cnt_inc;
    logic [7:0]                   r1_eff;

    always_comb
    begin
        ph_eff  = first_byte ? sdrd_pkg::PH_R1 : phase_reg;
        cnt_eff = first_byte ? '0 : count_reg;
        r1_eff  = first_byte ? 8'd0 : r1_reg;
        cnt_inc = cnt_eff + 1'b1;

        phase_next = ph_eff;
        count_next = cnt_eff;
        r1_next    = r1_eff;

        result            = '0;
        result.r1_value   = r1_eff;

        unique case (ph_eff)
            sdrd_pkg::PH_R1:
            begin
                if (rx_byte != sdrd_pkg::IDLE_BYTE)
                begin
                    r1_next         = rx_byte;
                    result.r1_value = rx_byte;
                    if (rx_byte[7:1] != 7'd0)
                    begin
                        phase_next    = sdrd_pkg::PH_DONE;
                        result.valid  = 1'b1;
                        result.last   = 1'b1;
                        result.status = sdrd_pkg::ST_R1_ERR;
                    end
                    else
                    begin
                        phase_next = sdrd_pkg::PH_TOKEN;
                        count_next = '0;
                    end
                end
                else
                begin
                    count_next = cnt_inc;
                    if (cnt_inc >= r1_limit)
                    begin
                        phase_next      = sdrd_pkg::PH_DONE;
                        result.valid    = 1'b1;
                        result.last     = 1'b1;
                        result.status   = sdrd_pkg::ST_NO_R1;
                        result.r1_value = 8'd0;
                    end
                end
            end
            sdrd_pkg::PH_TOKEN:
            begin
                if (rx_byte == sdrd_pkg::START_TOKEN)
                begin
                    phase_next = sdrd_pkg::PH_DATA;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt_inc;
                    if (cnt_inc >= sdrd_pkg::COUNT_W'(tok_limit))
                    begin
                        phase_next    = sdrd_pkg::PH_DONE;
                        result.valid  = 1'b1;
                        result.last   = 1'b1;
                        result.status = sdrd_pkg::ST_NO_TOKEN;
                    end
                end
            end
            sdrd_pkg::PH_DATA:
            begin
                result.valid      = 1'b1;
                result.data_byte  = rx_byte;
                result.byte_index = cnt_eff[sdrd_pkg::INDEX_W-1:0];
                result.status     = sdrd_pkg::ST_DATA;
                if (cnt_eff >= sdrd_pkg::LAST_COUNT)
                begin
                    result.last = 1'b1;
                    phase_next  = sdrd_pkg::PH_DONE;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            default:
            begin
                // idle or done: byte is dropped
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sdrd_pkg::PH_IDLE;
            count_reg <= '0;
            r1_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            r1_reg    <= r1_next;
        end
    end

endmodule

[rtl/sdrd_out_reg.sv]
// Result register feeding the master-side stream.
// Depends on sdrd_pkg.
`timescale 1ns / 1ps

module sdrd_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sdrd_pkg::result_t result,
    input  logic              take,
    output logic              out_valid,
    output sdrd_pkg::result_t out_item
);

    logic              valid_reg, valid_next;
    sdrd_pkg::result_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = result.valid;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
            item_reg <= result;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/sd_spi_read_response_deframer.sv]
// Top level of the SD card SPI-mode single-block read response deframer.
// Depends on sdrd_pkg, sdrd_parser and sdrd_out_reg.
`timescale 1ns / 1ps

// Takes card bytes one item per cycle while the output side keeps up and
// returns the 512 data bytes of a single-block read, or one error item
// (no R1, R1 error, no start token). A byte with the tuser flag set
// restarts the parse. Each accepted byte is held in an input register, is
// decoded against the parse state, and any result lands in an output
// register. Bytes with no result (R1 hunt, token hunt, CRC, trailing
// bytes) still pass through the input register. Limits are to be written
// by the user through the cfg port only while idle; the block does not
// enforce it. Index 0 = R1 search limit (13 bits, reset 8185), index 1 =
// token search limit (10 bits, reset 512). A limit of zero behaves as one.

module sd_spi_read_response_deframer
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic                            cfg_addr,
    input  logic [sdrd_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic                            s_tuser,   // [0] first_byte

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [7:0] data_byte, [16:8] byte_index,
                                                       // [24:17] r1_value, rest zero
    output logic                            m_tlast,   // last
    output logic [1:0]                      m_tuser    // [1:0] status
);

    logic [sdrd_pkg::R1_LIMIT_W-1:0]  r1_limit_reg;
    logic [sdrd_pkg::TOK_LIMIT_W-1:0] tok_limit_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    logic              advance;
    logic              out_valid;
    sdrd_pkg::result_t result;
    sdrd_pkg::result_t out_item;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_limit_reg  <= sdrd_pkg::R1_LIMIT_RST;
            tok_limit_reg <= sdrd_pkg::TOK_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                sdrd_pkg::CFG_R1_LIMIT:  r1_limit_reg  <= cfg_wdata[sdrd_pkg::R1_LIMIT_W-1:0];
                sdrd_pkg::CFG_TOK_LIMIT: tok_limit_reg <= cfg_wdata[sdrd_pkg::TOK_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // held item moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    sdrd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .r1_limit   (r1_limit_reg),
        .tok_limit  (tok_limit_reg),
        .advance    (advance),
        .rx_byte    (in_byte_reg),
        .first_byte (in_first_reg),
        .result     (result)
    );

    sdrd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .take      (m_tready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, out_item.r1_value, out_item.byte_index, out_item.data_byte};
    assign m_tlast  = out_item.last;
    assign m_tuser  = out_item.status;

endmodule
